// ===== src/nearest_scan_point_in_window_assert.svh =====
// Assertion helpers for the nearest-point scan block.
`ifndef NEAREST_SCAN_POINT_IN_WINDOW_ASSERT_SVH
`define NEAREST_SCAN_POINT_IN_WINDOW_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NSPW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nspw assertion failed");

// Next-cycle implication, checked out of reset.
`define NSPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nspw assertion failed");

`endif

// ===== src/nspw_pkg.sv =====
package nspw_pkg;

    // Range sample width actually used.
    localparam int RANGE_WIDTH = 16;
    localparam int RANGE_IN_W  = 16;

    // Sine table over one full turn, stored as one quarter wave.
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int QTR_N      = SINE_DEPTH / 4;
    localparam int QTR_W      = $clog2(QTR_N);
    localparam int SINE_MAG_W = 16;

    localparam int ANGLE_W = 16;
    localparam int STEP_W  = 12;
    localparam int LIMIT_W = 18;
    localparam int CFG_W   = 18;
    localparam int CFG_IDX_W = 3;

    localparam int PROD_W  = RANGE_WIDTH + SINE_MAG_W;
    localparam int COORD_W = RANGE_WIDTH + 2;
    localparam int CMP_W   = ((COORD_W > LIMIT_W) ? COORD_W : LIMIT_W) + 1;
    localparam int OUT_W   = 17;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1 << (ANGLE_W - 2));
    localparam logic [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(1 << (ANGLE_W - 1));

    localparam logic [ANGLE_W-1:0] START_ANGLE_RST = ANGLE_W'(49152);
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = STEP_W'(46);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT  = 3'd0,
        CFG_TOP    = 3'd1,
        CFG_LEFT   = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_START  = 3'd4,
        CFG_STEP   = 3'd5
    } t_cfg_idx;

    // Per-item control through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic first;
    } t_nspw_ctl;

    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } t_nspw_sine;

    typedef logic [SINE_MAG_W-1:0] t_sine_qtr [QTR_N];

    // Taylor divisors (2n)(2n+1), n = 1..7.
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'h4000_0000;

    // Q15 sine magnitude for quarter-wave position qi (0..QTR_N), Q30 series.
    function automatic logic [SINE_MAG_W-1:0] sine_q15(input int unsigned qi);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        r    = (longint'(qi) << 32) / SINE_DEPTH;
        x    = (r * PI_HALF_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) + 64'd16384) >> 15;
        return SINE_MAG_W'(q);
    endfunction

    function automatic t_sine_qtr build_sine_qtr();
        t_sine_qtr t;
        for (int i = 0; i < QTR_N; i++) begin
            t[i] = sine_q15(i);
        end
        return t;
    endfunction

    localparam t_sine_qtr SINE_QTR = build_sine_qtr();
    localparam logic [SINE_MAG_W-1:0] SINE_PEAK = sine_q15(QTR_N);

    // Full-turn table entry k as sign and magnitude, by quarter-wave symmetry.
    function automatic t_nspw_sine sine_lookup(input logic [IDX_W-1:0] k);
        t_nspw_sine       s;
        logic [1:0]       quad;
        logic [QTR_W-1:0] r;
        logic [QTR_W-1:0] r_mir;
        quad  = k[IDX_W-1 -: 2];
        r     = k[QTR_W-1:0];
        r_mir = QTR_W'(QTR_N - int'(r));
        s.neg = quad[1];
        if (quad[0] && (r == '0)) begin
            s.mag = SINE_PEAK;
        end else if (quad[0]) begin
            s.mag = SINE_QTR[r_mir];
        end else begin
            s.mag = SINE_QTR[r];
        end
        return s;
    endfunction

endpackage

// ===== src/nspw_if.sv =====
interface nspw_in_if import nspw_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [RANGE_IN_W-1:0] range_mm;
    logic                  scan_end;

    modport source (output valid, output range_mm, output scan_end, input ready);
    modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

interface nspw_out_if import nspw_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    found;

    modport source (output valid, output point_x, output point_y, output found, input ready);
    modport sink   (input valid, input point_x, input point_y, input found, output ready);
endinterface

// ===== src/nearest_scan_point_in_window.sv =====
// Nearest scan point inside a rectangular window. Range samples of one scan
// stream in on i_in, one item per sample, the last marked by scan_end. Each
// sample's beam angle is start_angle + n * angle_step (1/65536 turn, wrapping)
// plus a quarter turn; x = d*cos and y = d*sin come from a quarter-wave Q15
// sine table, truncated toward zero. A sample counts when it lies strictly
// inside the window (bottom < y < top, -left < x < right) and y > 0; the
// closest such sample wins, the earliest on a tie. On the scan_end sample one
// result item goes out: the winner's point with found = 1, or the point of
// the scan's first sample with found = 0 if nothing counted. Throughput is
// one sample per clock while i_in.ready is high. Four registers sit between
// i_in and o_out (angle register, table lookup, multiply, keep-best/output
// register), so a result is offered on o_out from the output register once
// its scan_end sample has passed the earlier three. i_in.ready drops only
// while a finished result is still waiting on o_out and the next scan's last
// sample reaches the keep-best stage. Configuration (i_cfg_we / i_cfg_idx /
// i_cfg_wdata) must be written by the user while idle; the block itself does
// not enforce this. start_angle is sampled on the first sample of each scan.
module nearest_scan_point_in_window import nspw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nspw_in_if.sink              i_in,
    nspw_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

`include "nearest_scan_point_in_window_assert.svh"

    // ---------------- configuration registers ----------------
    logic signed [LIMIT_W-1:0] r_right;
    logic signed [LIMIT_W-1:0] r_top;
    logic signed [LIMIT_W-1:0] r_left;
    logic signed [LIMIT_W-1:0] r_bottom;
    logic [ANGLE_W-1:0]        r_start_angle;
    logic [STEP_W-1:0]         r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right       <= '0;
            r_top         <= '0;
            r_left        <= '0;
            r_bottom      <= '0;
            r_start_angle <= START_ANGLE_RST;
            r_angle_step  <= ANGLE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RIGHT:  r_right       <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_TOP:    r_top         <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_LEFT:   r_left        <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_BOTTOM: r_bottom      <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_START:  r_start_angle <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_STEP:   r_angle_step  <= i_cfg_wdata[STEP_W-1:0];
                default: ;  // unused index: dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    t_nspw_ctl                 s3_ctl;
    logic [RANGE_WIDTH-1:0]    s3_d;
    logic signed [COORD_W-1:0] s3_x;
    logic signed [COORD_W-1:0] s3_y;

    logic r_out_valid;
    logic blocked;
    logic en;
    logic in_acc;

    // only a scan end needs the output slot; everything else flows
    assign blocked = s3_ctl.valid && s3_ctl.last && r_out_valid && !o_out.ready;
    assign en      = !blocked;
    assign i_in.ready = en;
    assign in_acc  = i_in.valid && en;

    // ---------------- stage 1: beam angle ----------------
    logic                   r_scan_started;
    logic [ANGLE_W-1:0]     r_beam;
    logic [ANGLE_W-1:0]     n_angle;
    t_nspw_ctl              r_ctl1;
    logic [RANGE_WIDTH-1:0] r_d1;
    logic [ANGLE_W-1:0]     r_ang1;

    assign n_angle = r_scan_started ? r_beam : r_start_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_started <= 1'b0;
            r_ctl1         <= '0;
        end else if (en) begin
            r_ctl1.valid <= i_in.valid;
            r_ctl1.last  <= i_in.scan_end;
            r_ctl1.first <= !r_scan_started;
            if (i_in.valid) begin
                r_scan_started <= !i_in.scan_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_beam <= n_angle + ANGLE_W'(r_angle_step);
            r_d1   <= i_in.range_mm[RANGE_WIDTH-1:0];
            r_ang1 <= n_angle;
        end
    end

    // ---------------- stages 2-3: x and y ----------------
    nspw_polar u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_ctl1),
        .i_range (r_d1),
        .i_angle (r_ang1),
        .o_ctl   (s3_ctl),
        .o_range (s3_d),
        .o_x     (s3_x),
        .o_y     (s3_y)
    );

    // ---------------- keep-best and result ----------------
    logic signed [CMP_W-1:0] x_c;
    logic signed [CMP_W-1:0] y_c;
    logic signed [CMP_W-1:0] right_c;
    logic signed [CMP_W-1:0] top_c;
    logic signed [CMP_W-1:0] bottom_c;
    logic signed [CMP_W-1:0] neg_left_c;
    logic                    in_window;
    logic                    take;
    logic                    consume;

    logic                      r_found;
    logic [RANGE_WIDTH-1:0]    r_best;
    logic signed [COORD_W-1:0] r_best_x;
    logic signed [COORD_W-1:0] r_best_y;
    logic signed [COORD_W-1:0] r_first_x;
    logic signed [COORD_W-1:0] r_first_y;

    logic signed [OUT_W-1:0] r_out_x;
    logic signed [OUT_W-1:0] r_out_y;
    logic                    r_out_found;
    logic signed [OUT_W-1:0] n_out_x;
    logic signed [OUT_W-1:0] n_out_y;
    logic                    n_out_found;

    always_comb begin
        x_c        = CMP_W'(s3_x);
        y_c        = CMP_W'(s3_y);
        right_c    = CMP_W'(r_right);
        top_c      = CMP_W'(r_top);
        bottom_c   = CMP_W'(r_bottom);
        neg_left_c = -CMP_W'(r_left);
        in_window  = (y_c < top_c) && (y_c > bottom_c) && (x_c < right_c) &&
                     (x_c > neg_left_c) && (y_c > CMP_W'(0));
        // strict less keeps the earliest on a tie
        take       = in_window && (!r_found || (s3_d < r_best));
        consume    = en && s3_ctl.valid;
    end

    always_comb begin
        if (take) begin
            n_out_x     = s3_x[OUT_W-1:0];
            n_out_y     = s3_y[OUT_W-1:0];
            n_out_found = 1'b1;
        end else if (r_found) begin
            n_out_x     = r_best_x[OUT_W-1:0];
            n_out_y     = r_best_y[OUT_W-1:0];
            n_out_found = 1'b1;
        end else if (s3_ctl.first) begin
            // single-sample scan: first point is this one
            n_out_x     = s3_x[OUT_W-1:0];
            n_out_y     = s3_y[OUT_W-1:0];
            n_out_found = 1'b0;
        end else begin
            n_out_x     = r_first_x[OUT_W-1:0];
            n_out_y     = r_first_y[OUT_W-1:0];
            n_out_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (consume) begin
            if (s3_ctl.last) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && take) begin
            r_best   <= s3_d;
            r_best_x <= s3_x;
            r_best_y <= s3_y;
        end
        if (consume && s3_ctl.first) begin
            r_first_x <= s3_x;
            r_first_y <= s3_y;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && s3_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && s3_ctl.last) begin
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_found <= n_out_found;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.point_x = r_out_x;
    assign o_out.point_y = r_out_y;
    assign o_out.found   = r_out_found;

    // ---------------- assertions ----------------
    `NSPW_ASSERT_NEXT(a_scan_end_restarts, i_clk, i_rst_n,
        in_acc && i_in.scan_end, !r_scan_started)
    `NSPW_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, in_acc, r_ctl1.valid)
    `NSPW_ASSERT_NOW(a_found_above_axis, i_clk, i_rst_n,
        r_out_valid && r_out_found, r_out_y > OUT_W'(0))

endmodule

// ===== src/nspw_polar.sv =====
// Polar to Cartesian: table lookup stage, then multiply-and-sign stage.
module nspw_polar import nspw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_nspw_ctl                 i_ctl,
    input  logic [RANGE_WIDTH-1:0]    i_range,
    input  logic [ANGLE_W-1:0]        i_angle,
    output t_nspw_ctl                 o_ctl,
    output logic [RANGE_WIDTH-1:0]    o_range,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y
);

    logic [ANGLE_W-1:0] phase_y;
    logic [ANGLE_W-1:0] phase_x;
    t_nspw_sine         n_ys;
    t_nspw_sine         n_xs;

    t_nspw_ctl              r_ctl2;
    logic [RANGE_WIDTH-1:0] r_d2;
    t_nspw_sine             r_ys;
    t_nspw_sine             r_xs;

    logic [PROD_W-1:0]        prod_y;
    logic [PROD_W-1:0]        prod_x;
    logic [RANGE_WIDTH:0]     mag_y;
    logic [RANGE_WIDTH:0]     mag_x;
    logic signed [COORD_W-1:0] n_y;
    logic signed [COORD_W-1:0] n_x;

    t_nspw_ctl                 r_ctl3;
    logic [RANGE_WIDTH-1:0]    r_d3;
    logic signed [COORD_W-1:0] r_x3;
    logic signed [COORD_W-1:0] r_y3;

    // y uses sin(a + quarter), x uses cos of that, i.e. one more quarter
    assign phase_y = i_angle + QUARTER_TURN;
    assign phase_x = i_angle + HALF_TURN;

    always_comb begin
        n_ys = sine_lookup(phase_y[ANGLE_W-1 -: IDX_W]);
        n_xs = sine_lookup(phase_x[ANGLE_W-1 -: IDX_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2 <= i_range;
            r_ys <= n_ys;
            r_xs <= n_xs;
        end
    end

    // magnitude product, truncated; sign applied after (toward zero)
    assign prod_y = PROD_W'(r_d2) * PROD_W'(r_ys.mag);
    assign prod_x = PROD_W'(r_d2) * PROD_W'(r_xs.mag);
    assign mag_y  = prod_y[PROD_W-1:15];
    assign mag_x  = prod_x[PROD_W-1:15];

    always_comb begin
        n_y = r_ys.neg ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
        n_x = r_xs.neg ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d3 <= r_d2;
            r_x3 <= n_x;
            r_y3 <= n_y;
        end
    end

    assign o_ctl   = r_ctl3;
    assign o_range = r_d3;
    assign o_x     = r_x3;
    assign o_y     = r_y3;

endmodule

// ===== test/tb_top.sv =====
// Testbench for nearest_scan_point_in_window.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nspw_pkg::*;

    // ---------------------------------------------------------------
    // Run constants
    // ---------------------------------------------------------------
    localparam int PIPE_DRAIN   = 8;     // margin for the pipe to empty
    localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int LONG_HOLD    = 300;   // output hold-off for the pressure test
    localparam int RANDOM_ITEMS = 1700;
    localparam int RANDOM_PHASES = 8;

    // Register indexes past the end of the map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // pi/2 in Q30, used to build the sine table.
    localparam longint unsigned PI_HALF_Q30_TB = 64'd1686629713;
    localparam longint unsigned ONE_Q30        = 64'h4000_0000;

    localparam logic [RANGE_WIDTH:0] NO_BEST = '1;

    localparam logic [CFG_W-1:0] LIM_MAX = 18'sd131071;
    localparam logic [CFG_W-1:0] LIM_MIN = 18'h20000;     // -131072

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic                    found;
    } t_point;

    // ---------------------------------------------------------------
    // Clock, reset, DUT
    // ---------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    always #5 i_clk = ~i_clk;

    nspw_in_if  in_if ();
    nspw_out_if out_if ();

    nearest_scan_point_in_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Predictor state: shadow registers and the per-scan tracking
    // ---------------------------------------------------------------
    logic [LIMIT_W-1:0]   lim_right, lim_top, lim_left, lim_bottom;
    logic [ANGLE_W-1:0]   start_angle_q;
    logic [STEP_W-1:0]    step_q;

    logic [ANGLE_W-1:0]   beam_angle;
    bit                   in_scan;
    logic [RANGE_WIDTH:0] best_dist;
    int                   best_x, best_y, first_x, first_y;

    int                   sine_tab [SINE_DEPTH];   // signed Q15, full turn

    t_point               expected_points [$];

    // Bookkeeping
    int  mismatches;
    int  samples_sent;
    int  scans_checked;
    int  scans_found;
    int  cfg_writes;
    int  stall_count;

    // Idle/backpressure knobs, driven from the test sequence
    bit  sender_idles;
    bit  receiver_idles;
    bit  long_hold_req;
    int  hold_left;

    // ---------------------------------------------------------------
    // Sine table: odd Taylor series in Q30 on the first quadrant,
    // folded to the full turn, rounded half up to Q15.
    // ---------------------------------------------------------------
    function automatic int sine_q15_at(input int k);
        longint unsigned frac, r, x, x2, term, mag;
        longint          acc;
        int              quad;
        frac = (longint'(k % SINE_DEPTH) << 32) / SINE_DEPTH;
        quad = int'((frac >> 30) & 64'd3);
        r    = frac & (ONE_Q30 - 64'd1);
        if (quad % 2 == 1) begin
            r = ONE_Q30 - r;
        end
        x    = (r * PI_HALF_Q30_TB) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = ($unsigned(acc) + 64'd16384) >> 15;
        return (quad >= 2) ? -int'(mag) : int'(mag);
    endfunction

    function automatic int phase_to_entry(input logic [ANGLE_W-1:0] ph);
        return (int'(ph) * SINE_DEPTH) >> 16;
    endfunction

    // sign(s) * ((d * |s|) >> 15): truncates toward zero
    function automatic int project(input int d, input int s);
        longint v;
        v = (longint'(d) * longint'(s < 0 ? -s : s)) >> 15;
        return s < 0 ? -int'(v) : int'(v);
    endfunction

    // Works out one sample's effect on the scan; on scan_end, queues the
    // nearest in-window point (or the first sample's point, found clear).
    function automatic void predict_nearest_point(input logic [RANGE_IN_W-1:0] dist_in,
                                                  input logic last);
        logic [RANGE_WIDTH-1:0] d;
        logic [ANGLE_W-1:0]     phase;
        int                     x, y;
        bit                     hit;
        t_point                 p;
        if (!in_scan) begin
            beam_angle = start_angle_q;
        end
        d     = dist_in[RANGE_WIDTH-1:0];
        phase = beam_angle + QUARTER_TURN;
        y     = project(int'(d), sine_tab[phase_to_entry(phase)]);
        x     = project(int'(d), sine_tab[phase_to_entry(phase + QUARTER_TURN)]);
        if (!in_scan) begin
            first_x = x;
            first_y = y;
        end
        hit = (y < int'($signed(lim_top))) && (y > int'($signed(lim_bottom))) &&
              (x < int'($signed(lim_right))) && (x > -int'($signed(lim_left))) && (y > 0);
        if (hit && (d < best_dist)) begin
            best_dist = d;
            best_x    = x;
            best_y    = y;
        end
        beam_angle = beam_angle + step_q;
        in_scan    = 1'b1;
        if (last) begin
            p.found   = (best_dist != NO_BEST);
            p.point_x = OUT_W'(p.found ? best_x : first_x);
            p.point_y = OUT_W'(p.found ? best_y : first_y);
            expected_points.push_back(p);
            in_scan   = 1'b0;
            best_dist = NO_BEST;
            best_x    = 0;
            best_y    = 0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            CFG_RIGHT:  lim_right     = data[LIMIT_W-1:0];
            CFG_TOP:    lim_top       = data[LIMIT_W-1:0];
            CFG_LEFT:   lim_left      = data[LIMIT_W-1:0];
            CFG_BOTTOM: lim_bottom    = data[LIMIT_W-1:0];
            CFG_START:  start_angle_q = data[ANGLE_W-1:0];
            CFG_STEP:   step_q        = data[STEP_W-1:0];
            default: ;  // unmapped index: dropped
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input side. Valid stays high across back-to-back items; an idle
    // burst lowers it at one falling edge and raises it at a later one.
    // ---------------------------------------------------------------
    task automatic send_sample(input logic [RANGE_IN_W-1:0] range_val, input logic last);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.range_mm <= range_val;
        in_if.scan_end <= last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
        predict_nearest_point(range_val, last);
    endtask

    // Stop offering, let every queued result land, then let the pipe empty
    // (samples without scan_end leave nothing to wait for).
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Leaves the write enable high so consecutive writes need no re-raise.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_window(input logic [CFG_W-1:0] right, input logic [CFG_W-1:0] top,
                               input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] bottom,
                               input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] step);
        wait_idle();
        write_reg(CFG_RIGHT, right);
        write_reg(CFG_TOP, top);
        write_reg(CFG_LEFT, left);
        write_reg(CFG_BOTTOM, bottom);
        write_reg(CFG_START, start);
        write_reg(CFG_STEP, step);
        end_writes();
    endtask

    function automatic logic [RANGE_IN_W-1:0] pick_dist(input int cap);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return RANGE_IN_W'($urandom);
            default: return RANGE_IN_W'($urandom_range(0, cap));
        endcase
    endfunction

    task automatic send_scan(input int n_samples, input int cap);
        for (int i = 0; i < n_samples; i++) begin
            send_sample(pick_dist(cap), i == n_samples - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // Output side: random ready bursts, plus one long hold on request
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            out_if.ready <= 1'b0;
        end else if (receiver_idles && $urandom_range(0, 19) == 0) begin
            hold_left     = $urandom_range(0, 14);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result: x=%0d y=%0d found=%0b",
                       out_if.point_x, out_if.point_y, out_if.found);
                mismatches++;
            end else begin
                want = expected_points.pop_front();
                scans_checked++;
                if (want.found) begin
                    scans_found++;
                end
                if (out_if.point_x !== want.point_x) begin
                    $error("point_x: expected %0d, got %0d", want.point_x, out_if.point_x);
                    mismatches++;
                end
                if (out_if.point_y !== want.point_y) begin
                    $error("point_y: expected %0d, got %0d", want.point_y, out_if.point_y);
                    mismatches++;
                end
                if (out_if.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, out_if.found);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long with nothing moving on either side ends the run
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset settings: all limits 0, so y > 0 and y < 0 clash and nothing
    // can qualify. Writes to the unmapped indexes must change nothing.
    task automatic test_reset_state();
        write_reg(CFG_SPARE_LO, LIM_MAX);
        write_reg(CFG_SPARE_HI, '1);
        end_writes();
        send_sample(16'd1000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        // single-sample scan of zero range
        send_sample(16'd0, 1'b1);
    endtask

    // Widest window, start straight ahead (y = d), largest step; two equal
    // ranges in a row check that the earlier one is kept. Then the narrowest
    // window with a zero step, where nothing can qualify.
    task automatic test_window_extremes();
        load_window(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MIN, '0, 18'd4095);
        send_sample(16'd40000, 1'b0);
        send_sample(16'd40000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd50000, 1'b1);
        load_window(LIM_MIN, LIM_MIN, LIM_MIN, LIM_MAX, 18'd65535, '0);
        send_sample(16'd30000, 1'b0);
        send_sample(16'd20, 1'b1);
    endtask

    // Scan paused with the pipe empty and registers rewritten: the new start
    // angle waits for the next scan, limits apply at once, the step after the next sample.
    task automatic test_mid_scan_config();
        load_window(18'd20000, 18'd30000, 18'd20000, 18'd0, 18'd60000, 18'd300);
        send_sample(16'd9000, 1'b0);
        send_sample(16'd8000, 1'b0);
        wait_idle();
        write_reg(CFG_START, 18'd1000);
        write_reg(CFG_STEP, 18'd1500);
        write_reg(CFG_TOP, 18'd60000);
        write_reg(CFG_LEFT, 18'd60000);
        end_writes();
        send_sample(16'd8500, 1'b0);
        send_sample(16'd7000, 1'b1);
        send_sample(16'd7000, 1'b1);
    endtask

    // Beam angle wraps past a full turn within one scan
    task automatic test_angle_wrap();
        load_window(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MIN, 18'd60000, 18'd4095);
        for (int i = 0; i < 12; i++) begin
            send_sample(RANGE_IN_W'(60000 - 3000 * i), i == 11);
        end
    endtask

    // Output held off for a long stretch while one-sample scans keep coming,
    // so the block fills up and drops its input ready.
    task automatic test_output_stall();
        load_window(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MIN, '0, 18'd46);
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_sample(RANGE_IN_W'($urandom), 1'b1);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_limit(input bit neg_side);
        case ($urandom_range(0, 7))
            0:       return LIM_MAX;
            1:       return LIM_MIN;
            2:       return '0;
            3:       return CFG_W'($urandom);
            default: return neg_side ? CFG_W'(-$urandom_range(0, 131072))
                                     : CFG_W'($urandom_range(1, 70000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 18'd4095;
            2:       return CFG_W'($urandom);    // upper bits must be dropped
            default: return CFG_W'($urandom_range(1, 400));
        endcase
    endfunction

    // Random scans in phases, each with its own window and angle setup.
    // Range caps vary so that small windows and close ties both show up.
    task automatic test_random_scans();
        int               target;
        int               cap;
        int               n_samples;
        logic [CFG_W-1:0] start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            start = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                : CFG_W'($urandom_range(0, 65535));
            load_window(pick_limit(1'b0), pick_limit(1'b0), pick_limit(1'b0),
                        pick_limit(1'b1), start, pick_step());
            // last phase runs at full rate on both sides
            sender_idles   = (ph != RANDOM_PHASES - 1);
            receiver_idles = (ph != RANDOM_PHASES - 1);
            target = samples_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (samples_sent < target) begin
                case ($urandom_range(0, 3))
                    0:       cap = 63;
                    1:       cap = 4095;
                    default: cap = 65535;
                endcase
                n_samples = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                        : $urandom_range(1, 24);
                send_scan(n_samples, cap);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        in_if.valid    = 1'b0;
        in_if.range_mm = '0;
        in_if.scan_end = 1'b0;
        out_if.ready   = 1'b0;

        lim_right      = '0;
        lim_top        = '0;
        lim_left       = '0;
        lim_bottom     = '0;
        start_angle_q  = START_ANGLE_RST;
        step_q         = ANGLE_STEP_RST;
        beam_angle     = '0;
        in_scan        = 1'b0;
        best_dist      = NO_BEST;
        best_x         = 0;
        best_y         = 0;
        first_x        = 0;
        first_y        = 0;

        mismatches     = 0;
        samples_sent   = 0;
        scans_checked  = 0;
        scans_found    = 0;
        cfg_writes     = 0;
        stall_count    = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        long_hold_req  = 1'b0;
        hold_left      = 0;

        for (int k = 0; k < SINE_DEPTH; k++) begin
            sine_tab[k] = sine_q15_at(k);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_window_extremes();
        test_mid_scan_config();
        test_angle_wrap();
        test_output_stall();
        test_random_scans();

        wait_idle();
        $display("Sent %0d range samples; checked %0d scan results, %0d with a hit.",
                 samples_sent, scans_checked, scans_found);
        $display("Register writes: %0d, covering limit and angle extremes.", cfg_writes);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
